[rtl/core/text_console_writer_unit_macros.svh]
// assertion helpers for the console writer back end (tcw_back)
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define TCW_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
// condition in one cycle implies a condition in the next
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: sequence check failed");
`else
`define TCW_ASSERT(label, prop)
`define TCW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/tcw_pkg.sv]
package tcw_pkg;

    // default geometry
    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int TAB_WIDTH_DEF   = 8;
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    // widest command fields over the whole parameter range
    localparam int CMD_COL_W = 8;
    localparam int CMD_ROW_W = 7;

    // cell contents
    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] BLANK_CHAR = 8'h20;

    // control bytes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [1:0] {
        MODE_PUT    = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_SETCUR = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUT,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_READ,
        OP_CLEAR,
        OP_SETCUR
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
        logic [6:0]  col;
        logic [4:0]  row;
    } in_item_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [15:0] cell_value;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t                  op;
        logic [7:0]           ch;
        logic [10:0]          idx;
        logic                 idx_ok;
        logic [CMD_COL_W-1:0] col;
        logic [CMD_ROW_W-1:0] row;
    } cmd_t;

endpackage

[rtl/core/tcw_ram.sv]
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/tcw_fifo.sv]
module tcw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/core/tcw_front.sv]
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  tcw_pkg::in_item_t request,
    output tcw_pkg::cmd_t     cmd
);

    import tcw_pkg::*;

    // decode the item into a command with clamped operands
    always_comb
    begin
        cmd.ch     = request.char_code;
        cmd.idx    = request.cell_index;
        cmd.idx_ok = (int'(request.cell_index) < COLUMNS * ROWS);
        cmd.col    = (int'(request.col) < COLUMNS) ? CMD_COL_W'(request.col)
                                                   : CMD_COL_W'(COLUMNS - 1);
        cmd.row    = (int'(request.row) < ROWS) ? CMD_ROW_W'(request.row)
                                                : CMD_ROW_W'(ROWS - 1);
        unique case (request.mode)
            MODE_PUT:
            begin
                unique case (request.char_code)
                    CH_NUL:  cmd.op = OP_NOP;
                    CH_BS:   cmd.op = OP_BS;
                    CH_TAB:  cmd.op = OP_TAB;
                    CH_CR:   cmd.op = OP_CR;
                    CH_LF:   cmd.op = OP_LF;
                    default: cmd.op = OP_PUT;
                endcase
            end
            MODE_READ:   cmd.op = OP_READ;
            MODE_CLEAR:  cmd.op = OP_CLEAR;
            MODE_SETCUR: cmd.op = OP_SETCUR;
        endcase
    end

endmodule

[rtl/core/tcw_back.sv]
`include "text_console_writer_unit_macros.svh"

module tcw_back #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               attribute_we,
    input  logic [7:0]         attribute_data,
    input  tcw_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output tcw_pkg::out_item_t res,
    input  logic               res_full,
    output logic               res_push
);

    import tcw_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int PH_W     = $clog2(TAB_WIDTH);
    localparam int TW       = COL_W + 5;
    localparam int COPY_LEN = COLUMNS * (ROWS - 1);

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_A     = ADDR_W'(COPY_LEN);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        attr_reg;

    logic              start;
    logic [ADDR_W-1:0] cur_pos, next_pos;
    logic [TW-1:0]     tab_sum;
    logic [PH_W-1:0]   mod_tbl [COLUMNS];

    logic [COL_W-1:0]  step_col;
    logic [ROW_W-1:0]  step_row;
    logic              row_adv, scroll_req;
    logic              put_we;
    logic [ADDR_W-1:0] put_addr;
    logic [15:0]       put_data;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_rdata;

    // column modulo tab width, one entry per column
    for (genvar g = 0; g < COLUMNS; g++)
    begin : g_tab
        assign mod_tbl[g] = PH_W'(g % TAB_WIDTH);
    end

    assign start    = (state_reg == ST_IDLE) && !cmd_empty && !res_full;
    assign cur_pos  = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign next_pos = ADDR_W'(row_next) * COLS_A + ADDR_W'(col_next);
    assign tab_sum  = TW'(col_reg) + TW'(TAB_WIDTH) - TW'(mod_tbl[col_reg]);

    // cursor step for put commands
    always_comb
    begin
        step_col = col_reg;
        row_adv  = 1'b0;
        put_we   = 1'b0;
        put_addr = cur_pos;
        put_data = {attr_reg, cmd.ch};
        case (cmd.op)
            OP_PUT:
            begin
                put_we = 1'b1;
                if (col_reg == COL_LAST)
                begin
                    step_col = '0;
                    row_adv  = 1'b1;
                end
                else
                begin
                    step_col = col_reg + 1'b1;
                end
            end
            OP_BS:
            begin
                if (col_reg != '0)
                begin
                    step_col = col_reg - 1'b1;
                    put_we   = 1'b1;
                    put_addr = cur_pos - 1'b1;
                    put_data = {attr_reg, BLANK_CHAR};
                end
            end
            OP_TAB:
            begin
                if (tab_sum >= TW'(COLUMNS))
                begin
                    step_col = '0;
                    row_adv  = 1'b1;
                end
                else
                begin
                    step_col = COL_W'(tab_sum);
                end
            end
            OP_CR:
            begin
                step_col = '0;
            end
            OP_LF:
            begin
                step_col = '0;
                row_adv  = 1'b1;
            end
            default:
            begin
            end
        endcase
        scroll_req = row_adv && (row_reg == ROW_LAST);
        step_row   = (row_adv && !scroll_req) ? row_reg + 1'b1 : row_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.op)
                        OP_READ:   state_next = cmd.idx_ok ? ST_READ : ST_IDLE;
                        OP_CLEAR:  state_next = ST_FILL;
                        OP_SETCUR: state_next = ST_IDLE;
                        default:   state_next = scroll_req ? ST_SCROLL : ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                if (addr_reg == COPY_A)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (addr_reg == CELL_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        addr_next = addr_reg;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {attr_reg, BLANK_CHAR};
        ram_re    = 1'b0;
        ram_raddr = addr_reg + COLS_A;
        cmd_pop   = 1'b0;
        res_push  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_READ:
                        begin
                            if (cmd.idx_ok)
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(cmd.idx);
                            end
                            else
                            begin
                                res_push = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            col_next  = '0;
                            row_next  = '0;
                            addr_next = '0;
                        end
                        OP_SETCUR:
                        begin
                            col_next = COL_W'(cmd.col);
                            row_next = ROW_W'(cmd.row);
                            res_push = 1'b1;
                        end
                        default:
                        begin
                            col_next  = step_col;
                            row_next  = step_row;
                            ram_we    = put_we;
                            ram_waddr = put_addr;
                            ram_wdata = put_data;
                            if (scroll_req)
                            begin
                                addr_next = '0;
                            end
                            else
                            begin
                                res_push = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_push = 1'b1;
            end
            ST_SCROLL:
            begin
                // read one row below, write the cell read in the previous cycle
                ram_re    = (addr_reg != COPY_A);
                ram_we    = (addr_reg != '0);
                ram_waddr = addr_reg - 1'b1;
                ram_wdata = ram_rdata;
                if (addr_reg != COPY_A)
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (addr_reg == CELL_LAST)
                begin
                    res_push = 1'b1;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
        endcase
    end

    // result item
    assign res.cursor_pos = 11'(next_pos);
    assign res.cell_value = (state_reg == ST_READ) ? ram_rdata : 16'h0000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            addr_reg  <= '0;
            attr_reg  <= ATTR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            addr_reg  <= addr_next;
            if (attribute_we)
            begin
                attr_reg <= attribute_data;
            end
        end
    end

    // screen memory
    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // checks
    `TCW_ASSERT(a_push_has_room, res_push |-> !res_full)
    `TCW_ASSERT(a_pop_only_idle, cmd_pop |-> (state_reg == ST_IDLE))
    `TCW_ASSERT_NEXT(a_read_one_cycle, state_reg == ST_READ, state_reg == ST_IDLE)
    `TCW_ASSERT(a_cursor_on_screen, (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
    `TCW_ASSERT_NEXT(a_scroll_from_bottom, state_reg == ST_SCROLL, row_reg == ROW_LAST)

endmodule

[rtl/core/text_console_writer_unit.sv]
// Character cell console writer, COLUMNS x ROWS cells of 16 bits (attribute in the
// high byte, character in the low byte) with a teletype style cursor. Items enter a
// small command queue and are carried out one at a time by a sequencer around a
// single screen memory with one write and one registered read port; every item gives
// one result with the cursor position. Put items that do not scroll, set-cursor and
// out-of-range read items finish straight from the idle state; an in-range read also
// passes through a read state for the registered memory read. A put that runs past
// the bottom row then scrolls: the sequencer copies each row up one row, then blanks
// the bottom row. Clear writes every cell. Screen contents are undefined after reset
// until the first clear.
module text_console_writer_unit #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tcw_pkg::in_item_t  request,
    input  logic               pop,
    output logic               empty,
    output tcw_pkg::out_item_t result,
    input  logic               attribute_we,
    input  logic [7:0]         attribute_data
);

    import tcw_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(out_item_t);

    cmd_t       front_cmd, back_cmd;
    logic [CMD_W-1:0] cmd_q_rdata;
    logic       cmd_empty, cmd_pop;
    out_item_t  back_res;
    logic [RES_W-1:0] res_q_rdata;
    logic       res_full, res_push;

    // classify items
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .request (request),
        .cmd     (front_cmd)
    );

    // command queue between front and back
    tcw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_q_rdata),
        .empty (cmd_empty)
    );

    assign back_cmd = cmd_t'(cmd_q_rdata);

    // sequencer and screen memory
    tcw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .attribute_we   (attribute_we),
        .attribute_data (attribute_data),
        .cmd            (back_cmd),
        .cmd_empty      (cmd_empty),
        .cmd_pop        (cmd_pop),
        .res            (back_res),
        .res_full       (res_full),
        .res_push       (res_push)
    );

    // result queue
    tcw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_q_rdata),
        .empty (empty)
    );

    assign result = out_item_t'(res_q_rdata);

endmodule

[dv/tb_text_console_writer_unit.sv]
module tb_text_console_writer_unit;

    import tcw_pkg::*;

    localparam int COLS        = COLUMNS_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int TABW        = TAB_WIDTH_DEF;
    localparam int CELLS       = COLS * ROWS;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 150;
    localparam int STALL_LIMIT = 20000;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    in_item_t   request;
    logic       pop;
    logic       empty;
    out_item_t  result;
    logic       attribute_we;
    logic [7:0] attribute_data;

    // shadow of the console: cursor, attribute and every cell
    int          shadow_col;
    int          shadow_row;
    logic [7:0]  shadow_attr;
    logic [15:0] shadow_screen [CELLS];

    out_item_t console_answers_q [$];
    int        mismatch_count;

    text_console_writer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .request        (request),
        .pop            (pop),
        .empty          (empty),
        .result         (result),
        .attribute_we   (attribute_we),
        .attribute_data (attribute_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch: %s got 0x%0h want 0x%0h", what, got, want);
        mismatch_count++;
    endtask

    // apply one item to the shadow console and return its answer
    function automatic out_item_t advance_console(in_item_t it);
        out_item_t ans;
        logic [15:0] blank;
        int i;
        ans = '0;
        blank = {shadow_attr, BLANK_CHAR};
        case (it.mode)
            MODE_PUT:
            begin
                case (it.char_code)
                    CH_NUL: ;
                    CH_BS:
                    begin
                        if (shadow_col > 0)
                        begin
                            shadow_col--;
                            shadow_screen[shadow_row * COLS + shadow_col] = blank;
                        end
                    end
                    CH_TAB:
                    begin
                        shadow_col = shadow_col + TABW - (shadow_col % TABW);
                        if (shadow_col >= COLS)
                        begin
                            shadow_col = 0;
                            shadow_row++;
                        end
                    end
                    CH_CR: shadow_col = 0;
                    CH_LF:
                    begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                    default:
                    begin
                        shadow_screen[shadow_row * COLS + shadow_col] =
                            {shadow_attr, it.char_code};
                        shadow_col++;
                        if (shadow_col >= COLS)
                        begin
                            shadow_col = 0;
                            shadow_row++;
                        end
                    end
                endcase
                // ran off the bottom: scroll up one row and blank the last one
                if (shadow_row >= ROWS)
                begin
                    for (i = 0; i < COLS * (ROWS - 1); i++)
                        shadow_screen[i] = shadow_screen[i + COLS];
                    for (i = COLS * (ROWS - 1); i < CELLS; i++)
                        shadow_screen[i] = blank;
                    shadow_row = ROWS - 1;
                end
            end
            MODE_READ:
            begin
                if (it.cell_index < CELLS)
                    ans.cell_value = shadow_screen[it.cell_index];
            end
            MODE_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    shadow_screen[i] = blank;
                shadow_col = 0;
                shadow_row = 0;
            end
            default:
            begin
                shadow_col = (it.col < COLS) ? int'(it.col) : COLS - 1;
                shadow_row = (it.row < ROWS) ? int'(it.row) : ROWS - 1;
            end
        endcase
        ans.cursor_pos = 11'(shadow_row * COLS + shadow_col);
        return ans;
    endfunction

    function automatic dir_row_t stim_row(mode_t m, logic [7:0] ch, int idx, int c, int r,
                                          bit typed, int pos, int val);
        dir_row_t d;
        d.stim.mode       = m;
        d.stim.char_code  = ch;
        d.stim.cell_index = 11'(idx);
        d.stim.col        = 7'(c);
        d.stim.row        = 5'(r);
        d.typed           = typed;
        d.want.cursor_pos = 11'(pos);
        d.want.cell_value = 16'(val);
        return d;
    endfunction

    // hold one item on the input until it is taken, then log its answer
    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        out_item_t predicted;
        push    <= 1'b1;
        request <= it;
        do
            @(posedge clk);
        while (full);
        predicted = advance_console(it);
        console_answers_q.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drain();
        while (console_answers_q.size() != 0)
            @(posedge clk);
    endtask

    // sender
    initial
    begin
        dir_row_t   directed_rows [$];
        in_item_t   it;
        logic [7:0] new_attr;
        int         burst_left;
        int         gap;
        int         max_gap;
        int         pick;
        int         sub;

        rst_n          <= 1'b0;
        push           <= 1'b0;
        request        <= '0;
        attribute_we   <= 1'b0;
        attribute_data <= '0;
        mismatch_count = 0;
        shadow_col     = 0;
        shadow_row     = 0;
        shadow_attr    = ATTR_RESET;
        foreach (shadow_screen[i])
            shadow_screen[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items, reset attribute
        directed_rows = '{
            stim_row(MODE_PUT,    8'h41,  0,   0,  0, 1'b1,    1, 16'h0000),
            stim_row(MODE_READ,   8'h00,  0,   0,  0, 1'b1,    1, 16'h0741),
            stim_row(MODE_CLEAR,  8'hFF,  0,   0,  0, 1'b1,    0, 16'h0000),
            stim_row(MODE_READ,   8'h00, 1999, 0,  0, 1'b1,    0, 16'h0720),
            stim_row(MODE_READ,   8'h00, 2047, 0,  0, 1'b1,    0, 16'h0000),
            stim_row(MODE_READ,   8'h00, 2000, 0,  0, 1'b1,    0, 16'h0000),
            stim_row(MODE_SETCUR, 8'h00,  0, 127, 31, 1'b1, 1999, 16'h0000),
            stim_row(MODE_PUT,    8'hFF,  0,   0,  0, 1'b1, 1920, 16'h0000),
            stim_row(MODE_READ,   8'h00, 1919, 0,  0, 1'b1, 1920, 16'h07FF),
            stim_row(MODE_READ,   8'h00, 1920, 0,  0, 1'b1, 1920, 16'h0720),
            stim_row(MODE_SETCUR, 8'h00,  0,  79,  0, 1'b1,   79, 16'h0000),
            stim_row(MODE_PUT,    CH_TAB, 0,   0,  0, 1'b1,   80, 16'h0000),
            stim_row(MODE_SETCUR, 8'h00,  0,   3,  1, 1'b1,   83, 16'h0000),
            stim_row(MODE_PUT,    CH_TAB, 0,   0,  0, 1'b1,   88, 16'h0000),
            stim_row(MODE_PUT,    CH_BS,  0,   0,  0, 1'b1,   87, 16'h0000),
            stim_row(MODE_READ,   8'h00, 87,   0,  0, 1'b1,   87, 16'h0720),
            stim_row(MODE_SETCUR, 8'h00,  0,   0,  2, 1'b1,  160, 16'h0000),
            stim_row(MODE_PUT,    CH_BS,  0,   0,  0, 1'b1,  160, 16'h0000),
            stim_row(MODE_PUT,    CH_NUL, 0,   0,  0, 1'b1,  160, 16'h0000),
            stim_row(MODE_PUT,    8'h78,  0,   0,  0, 1'b0,    0, 0),
            stim_row(MODE_PUT,    CH_CR,  0,   0,  0, 1'b1,  160, 16'h0000),
            stim_row(MODE_PUT,    CH_LF,  0,   0,  0, 1'b1,  240, 16'h0000),
            stim_row(MODE_SETCUR, 8'h00,  0,   5, 24, 1'b1, 1925, 16'h0000),
            stim_row(MODE_PUT,    8'h80,  0,   0,  0, 1'b0,    0, 0),
            stim_row(MODE_PUT,    CH_LF,  0,   0,  0, 1'b1, 1920, 16'h0000),
            stim_row(MODE_READ,   8'h00, 1845, 0,  0, 1'b1, 1920, 16'h0780)
        };
        foreach (directed_rows[k])
            send_item(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);
        push <= 1'b0;

        // random phases, each under its own attribute and sender pacing
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drain();
            case (ph)
                0: new_attr = 8'h00;
                1: new_attr = 8'hFF;
                2: new_attr = 8'($urandom_range(1, 254));
                default: new_attr = 8'h1E;
            endcase
            max_gap = (ph == 0) ? 0 : 4 * ph;
            attribute_we   <= 1'b1;
            attribute_data <= new_attr;
            @(posedge clk);
            shadow_attr = new_attr;
            attribute_we <= 1'b0;

            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
                    if (gap > 0)
                    begin
                        push <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;

                // random item, unused fields left random
                it.char_code  = 8'($urandom);
                it.cell_index = 11'($urandom);
                it.col        = 7'($urandom);
                it.row        = 5'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 58)
                begin
                    it.mode = MODE_PUT;
                    sub = $urandom_range(0, 9);
                    if (sub < 6)
                        it.char_code = 8'($urandom_range(8'h20, 8'h7E));
                    else if (sub < 8)
                    begin
                        case ($urandom_range(0, 4))
                            0: it.char_code = CH_NUL;
                            1: it.char_code = CH_BS;
                            2: it.char_code = CH_TAB;
                            3: it.char_code = CH_CR;
                            default: it.char_code = CH_LF;
                        endcase
                    end
                end
                else if (pick < 74)
                begin
                    it.mode = MODE_READ;
                    if ($urandom_range(0, 7) != 0)
                        it.cell_index = 11'($urandom_range(0, CELLS - 1));
                end
                else if (pick < 77)
                    it.mode = MODE_CLEAR;
                else
                begin
                    it.mode = MODE_SETCUR;
                    if ($urandom_range(0, 3) != 0)
                    begin
                        it.col = 7'($urandom_range(0, COLS - 1));
                        it.row = $urandom_range(0, 1) ? 5'(ROWS - 1)
                                                      : 5'($urandom_range(0, ROWS - 1));
                    end
                end
                send_item(it, 1'b0, '0);
            end
            push <= 1'b0;
        end

        wait_drain();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver: check each taken result, stall on a shifting pattern
    initial
    begin
        out_item_t want;
        int        cyc;
        int        stall_style;
        int        hold;
        logic      next_pop;

        pop <= 1'b0;
        cyc = 0;
        stall_style = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (console_answers_q.size() == 0)
                    report_mismatch("result with nothing pending", 32'(result), 0);
                else
                begin
                    want = console_answers_q.pop_front();
                    if (result.cursor_pos !== want.cursor_pos)
                        report_mismatch("cursor_pos", 32'(result.cursor_pos),
                                        32'(want.cursor_pos));
                    if (result.cell_value !== want.cell_value)
                        report_mismatch("cell_value", 32'(result.cell_value),
                                        32'(want.cell_value));
                end
            end
            cyc++;
            if (cyc % 128 == 0)
                stall_style = $urandom_range(0, 3);
            case (stall_style)
                0: next_pop = 1'b1;
                1: next_pop = 1'($urandom_range(0, 1));
                2: next_pop = (cyc % 5) == 0;
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        next_pop = 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        hold = $urandom_range(10, 40);
                        next_pop = 1'b0;
                    end
                    else
                        next_pop = 1'b1;
                end
            endcase
            pop <= next_pop;
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
